// File: rtl/core/lsb_pkg.sv
package lsb_pkg;

   // Widths of the duty path, sine table and period, and other fixed limits.
   localparam int DUTY_W        = 8;
   localparam int SINE_STEPS    = 256;
   localparam int SINE_BITS     = 8;
   localparam int PERIOD_W      = 16;
   localparam int RATE_LIMIT_MS = 15;
   localparam int MIN_PERIOD_MS = 200;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // Fixed-point constants used while building the sine table.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [1:0] {
      OP_OFF,
      OP_BRIGHT,
      OP_PULSE,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_BRIGHT,
      MODE_PULSE
   } mode_type;

   typedef enum logic [1:0] {
      CSR_BRIGHT_LEVEL,
      CSR_PULSE_LOW,
      CSR_PULSE_HIGH,
      CSR_PERIOD_MS
   } csr_index_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_LOOKUP,
      BACK_SCALE,
      BACK_FINISH
   } back_state_type;

   // Configuration registers as seen by the front and back ends.
   typedef struct packed {
      logic [DUTY_W-1:0]   bright_level;
      logic [DUTY_W-1:0]   pulse_low;
      logic [DUTY_W-1:0]   pulse_high;
      logic [PERIOD_W-1:0] period_ms;
   } cfg_type;

   typedef logic [DUTY_W-1:0] sine_rom_type [SINE_STEPS];

   // Builds the normalized sine table, (sin + 1) / 2 in Q0.8. The sine of the
   // first quadrant is evaluated in Q30 with an eight-term Taylor series and
   // mirrored into the other three quadrants.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type       rom;
      logic [63:0]        p;
      logic [63:0]        q;
      logic [63:0]        r;
      logic [63:0]        u;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        s;
      logic [63:0]        half;
      logic [63:0]        mag;
      logic [63:0]        v;
      half = 64'd1 << (DUTY_W - 1);
      for (int i = 0; i < SINE_STEPS; i++) begin
         p = 64'(4 * i);
         q = p / SINE_STEPS;
         r = p % SINE_STEPS;
         u = q[0] ? (64'(SINE_STEPS) - r) : r;
         x = (u * HALF_PI_Q30) / SINE_STEPS;
         x2 = (x * x) >> 30;
         term = x;
         sum = $signed(x);
         term = ((term * x2) >> 30) / 6;
         sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 20;
         sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 42;
         sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 72;
         sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 110;
         sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 156;
         sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 210;
         sum = sum - $signed(term);
         if (sum < 0) begin
            sum = 64'sd0;
         end
         s = $unsigned(sum);
         mag = (s * half + (ONE_Q30 >> 1)) >> 30;
         if (mag > half) begin
            mag = half;
         end
         if (q >= 64'd2) begin
            v = half - mag;
         end else begin
            v = half + mag;
         end
         if (v > 64'((1 << DUTY_W) - 1)) begin
            v = 64'((1 << DUTY_W) - 1);
         end
         rom[i] = v[DUTY_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/led_sine_breathing_pwm.sv
// Sine breathing LED duty generator. Each request word carries an operation
// (off, bright, start pulse, tick) and a millisecond timestamp. Off and bright
// put one duty word on the response port, through the queue and the response
// register; start pulse answers with nothing; a tick in breathing mode that is
// the first since start pulse or at least 15 ms after the last update answers
// with a duty taken from a 256-entry normalized sine table and scaled between
// the low and high pulse levels. A request is taken whenever the two-entry
// queue between the classifier and the datapath has room. A breathing update
// leaves the queue, passes the bit-serial divider that forms the period
// remainder and the table index, then the table read, the scaling multiply and
// the output register. The result register lets the next queued tick start
// while a duty waits to be taken. Configuration writes take effect at once and
// are meant for idle time.
module led_sine_breathing_pwm
   import lsb_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [TIME_BITS-1:0]   req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DUTY_W-1:0]      rsp_duty,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 push_en;
   logic [TIME_BITS:0]   push_data;
   logic                 queue_full;
   logic                 pop_en;
   logic [TIME_BITS:0]   pop_data;
   logic                 queue_empty;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_BRIGHT_LEVEL: cfg_in.bright_level = csr_wdata[DUTY_W-1:0];
            CSR_PULSE_LOW:    cfg_in.pulse_low    = csr_wdata[DUTY_W-1:0];
            CSR_PULSE_HIGH:   cfg_in.pulse_high   = csr_wdata[DUTY_W-1:0];
            CSR_PERIOD_MS:    cfg_in.period_ms    = csr_wdata[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_level <= DUTY_W'(255);
         cfg_ff.pulse_low    <= DUTY_W'(40);
         cfg_ff.pulse_high   <= DUTY_W'(255);
         cfg_ff.period_ms    <= PERIOD_W'(1500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsb_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_now_ms (req_now_ms),
      .queue_full (queue_full),
      .push_en    (push_en),
      .push_data  (push_data)
   );

   lsb_queue #(
      .WIDTH (TIME_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .full      (queue_full),
      .pop_en    (pop_en),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   lsb_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop_en      (pop_en),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_duty    (rsp_duty)
   );

endmodule

// File: rtl/core/lsb_queue.sv
module lsb_queue
   import lsb_pkg::*;
#(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop_en,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   assign full     = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointers wrap at the queue depth; the count follows pushes and pops.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_en && full && !pop_en))
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop_en && empty))
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      push_en && !pop_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

// File: rtl/core/lsb_front.sv
module lsb_front
   import lsb_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [TIME_BITS-1:0] req_now_ms,
   input  logic                 queue_full,
   output logic                 push_en,
   output logic [TIME_BITS:0]   push_data
);

   mode_type             mode_ff;
   mode_type             mode_in;
   logic [TIME_BITS-1:0] last_ff;
   logic [TIME_BITS-1:0] last_in;
   logic                 fire;
   op_type               op;
   logic [TIME_BITS-1:0] elapsed;
   logic                 tick_due;

   assign req_ready = !queue_full;
   assign fire      = req_valid && req_ready;
   assign op        = op_type'(req_op);

   // A tick is due when no update has been stored yet or the last one is old enough.
   assign elapsed  = req_now_ms - last_ff;
   assign tick_due = (last_ff == '0) || (elapsed >= TIME_BITS'(RATE_LIMIT_MS));

   // Classify each word: steady levels go out as a duty, due ticks go to the back end.
   always_comb begin
      mode_in   = mode_ff;
      last_in   = last_ff;
      push_en   = 1'b0;
      push_data = '0;
      if (fire) begin
         case (op)
            OP_OFF: begin
               mode_in = MODE_OFF;
               push_en = 1'b1;
            end
            OP_BRIGHT: begin
               mode_in                   = MODE_BRIGHT;
               push_en                   = 1'b1;
               push_data[TIME_BITS-1:0]  = TIME_BITS'(cfg.bright_level);
            end
            OP_PULSE: begin
               mode_in = MODE_PULSE;
               last_in = '0;
            end
            OP_TICK: begin
               if ((mode_ff == MODE_PULSE) && tick_due) begin
                  last_in                  = req_now_ms;
                  push_en                  = 1'b1;
                  push_data[TIME_BITS]     = 1'b1;
                  push_data[TIME_BITS-1:0] = req_now_ms;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         last_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         last_ff <= last_in;
      end
   end

   a_tick_updates_time: assert property (@(posedge clock) disable iff (reset)
      push_en && push_data[TIME_BITS] |=> last_ff == $past(req_now_ms))
      else $error("dispatched tick did not record its time");

endmodule

// File: rtl/core/lsb_back.sv
module lsb_back
   import lsb_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               queue_empty,
   input  logic [TIME_BITS:0] pop_data,
   output logic               pop_en,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DUTY_W-1:0]  rsp_duty
);

   localparam int STEPS   = TIME_BITS + SINE_BITS;
   localparam int COUNT_W = $clog2(STEPS);

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic [PERIOD_W-1:0]    rem_ff;
   logic [PERIOD_W-1:0]    rem_in;
   logic [TIME_BITS-1:0]   dividend_ff;
   logic [TIME_BITS-1:0]   dividend_in;
   logic [SINE_BITS-1:0]   idx_ff;
   logic [SINE_BITS-1:0]   idx_in;
   logic [DUTY_W-1:0]      norm_ff;
   logic [DUTY_W-1:0]      norm_in;
   logic [2*DUTY_W-1:0]    prod_ff;
   logic [2*DUTY_W-1:0]    prod_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [DUTY_W-1:0]      rsp_duty_ff;
   logic [DUTY_W-1:0]      rsp_duty_in;

   logic                   slot_free;
   logic                   is_tick;
   logic [PERIOD_W-1:0]    per;
   logic [DUTY_W-1:0]      lo;
   logic [DUTY_W-1:0]      hi;
   logic [DUTY_W-1:0]      span;
   logic [PERIOD_W:0]      shifted;
   logic                   ge;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty  = rsp_duty_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_tick   = pop_data[TIME_BITS];

   // Clamped period and ordered breathing levels.
   assign per  = (cfg.period_ms < PERIOD_W'(MIN_PERIOD_MS)) ? PERIOD_W'(MIN_PERIOD_MS)
                                                            : cfg.period_ms;
   assign lo   = (cfg.pulse_low > cfg.pulse_high) ? cfg.pulse_high : cfg.pulse_low;
   assign hi   = (cfg.pulse_low > cfg.pulse_high) ? cfg.pulse_low : cfg.pulse_high;
   assign span = hi - lo;

   // One restoring step: the time bits come first, then zeros for the table index.
   assign shifted = {rem_ff, dividend_ff[TIME_BITS-1]};
   assign ge      = (shifted >= {1'b0, per});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty && is_tick) begin
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (count_ff == COUNT_W'(STEPS - 1)) begin
               state_in = BACK_LOOKUP;
            end
         end
         BACK_LOOKUP: state_in = BACK_SCALE;
         BACK_SCALE:  state_in = BACK_FINISH;
         BACK_FINISH: begin
            if (slot_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pop_en       = 1'b0;
      count_in     = count_ff;
      rem_in       = rem_ff;
      dividend_in  = dividend_ff;
      idx_in       = idx_ff;
      norm_in      = norm_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_duty_in  = rsp_duty_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty && is_tick) begin
               pop_en      = 1'b1;
               dividend_in = pop_data[TIME_BITS-1:0];
               rem_in      = '0;
               count_in    = '0;
               idx_in      = '0;
            end else if (!queue_empty && slot_free) begin
               pop_en       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_duty_in  = pop_data[DUTY_W-1:0];
            end
         end
         BACK_DIVIDE: begin
            rem_in      = ge ? PERIOD_W'(shifted - {1'b0, per}) : shifted[PERIOD_W-1:0];
            dividend_in = {dividend_ff[TIME_BITS-2:0], 1'b0};
            idx_in      = {idx_ff[SINE_BITS-2:0], ge};
            count_in    = count_ff + 1'b1;
         end
         BACK_LOOKUP: begin
            norm_in = SINE_ROM[idx_ff];
         end
         BACK_SCALE: begin
            prod_in = norm_ff * span;
         end
         BACK_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = lo + prod_ff[2*DUTY_W-1:DUTY_W];
            end
         end
         default: begin
            pop_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      idx_ff      <= idx_in;
      norm_ff     <= norm_in;
      prod_ff     <= prod_in;
      rsp_duty_ff <= rsp_duty_in;
   end

   a_rem_below_period: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_LOOKUP |-> rem_ff < per)
      else $error("division remainder not below the period");

   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_FINISH && slot_free |=>
         rsp_valid_ff && rsp_duty_ff >= lo && rsp_duty_ff <= hi)
      else $error("breathing duty outside the pulse levels");

endmodule

// File: dv/led_sine_breathing_pwm_tb.sv
// Tracks the breathing duty generator word by word. It keeps a private copy of
// the registers, the mode, the last update time and the normalized sine table.
class duty_scoreboard;

   bit [7:0]              bright_level;
   bit [7:0]              pulse_low;
   bit [7:0]              pulse_high;
   bit [15:0]             period_ms;
   lsb_pkg::mode_type     mode;
   bit [31:0]             last_update;
   bit [7:0]              wave [lsb_pkg::SINE_STEPS];
   bit [7:0]              expected_duty [$];
   int                    errors;
   int                    words_in;
   int                    words_out;
   int                    updates;
   int                    limited;

   function new();
      build_wave();
      bright_level = 8'd255;
      pulse_low    = 8'd40;
      pulse_high   = 8'd255;
      period_ms    = 16'd1500;
      mode         = lsb_pkg::MODE_OFF;
      last_update  = '0;
   endfunction

   // One quadrant of sine in Q30 by an eight-term Taylor series, mirrored to a
   // full period and mapped to (sin + 1) / 2 in Q0.8 with rounding.
   function void build_wave();
      bit [63:0] p;
      bit [63:0] q;
      bit [63:0] r;
      bit [63:0] u;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      bit [63:0] s;
      bit [63:0] mag;
      bit [63:0] v;
      bit [63:0] half;
      longint    sum;
      half = 64'd1 << (lsb_pkg::DUTY_W - 1);
      for (int i = 0; i < lsb_pkg::SINE_STEPS; i++) begin
         p = 64'(4 * i);
         q = p / 64'(lsb_pkg::SINE_STEPS);
         r = p % 64'(lsb_pkg::SINE_STEPS);
         u = q[0] ? (64'(lsb_pkg::SINE_STEPS) - r) : r;
         x = (u * lsb_pkg::HALF_PI_Q30) / 64'(lsb_pkg::SINE_STEPS);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
               sum -= longint'(term);
            end else begin
               sum += longint'(term);
            end
         end
         s = (sum < 0) ? 64'd0 : 64'(sum);
         mag = (s * half + (lsb_pkg::ONE_Q30 >> 1)) >> 30;
         if (mag > half) begin
            mag = half;
         end
         v = (q >= 64'd2) ? (half - mag) : (half + mag);
         if (v > 64'd255) begin
            v = 64'd255;
         end
         wave[i] = v[7:0];
      end
   endfunction

   function void write_reg(lsb_pkg::csr_index_type index, bit [15:0] data);
      case (index)
         lsb_pkg::CSR_BRIGHT_LEVEL: bright_level = data[7:0];
         lsb_pkg::CSR_PULSE_LOW:    pulse_low    = data[7:0];
         lsb_pkg::CSR_PULSE_HIGH:   pulse_high   = data[7:0];
         lsb_pkg::CSR_PERIOD_MS:    period_ms    = data;
         default: ;
      endcase
   endfunction

   // Duty of one breathing update: phase within the period, table lookup and
   // scaling between the ordered pulse levels.
   function bit [7:0] breathe_duty(bit [31:0] now);
      bit [31:0] per;
      bit [31:0] phase;
      bit [31:0] index;
      bit [7:0]  lo;
      bit [7:0]  hi;
      bit [15:0] prod;
      per = (period_ms < lsb_pkg::MIN_PERIOD_MS) ? 32'(lsb_pkg::MIN_PERIOD_MS)
                                                 : 32'(period_ms);
      lo = pulse_low;
      hi = pulse_high;
      if (lo > hi) begin
         lo = pulse_high;
         hi = pulse_low;
      end
      phase = now % per;
      index = (phase * 32'(lsb_pkg::SINE_STEPS)) / per;
      if (index >= lsb_pkg::SINE_STEPS) begin
         index = lsb_pkg::SINE_STEPS - 1;
      end
      prod = 16'(wave[index]) * 16'(hi - lo);
      return lo + prod[15:8];
   endfunction

   // Called for every accepted request word.
   function void note_request(lsb_pkg::op_type op, bit [31:0] now);
      bit [31:0] age;
      words_in++;
      case (op)
         lsb_pkg::OP_OFF: begin
            mode = lsb_pkg::MODE_OFF;
            expected_duty.push_back(8'd0);
         end
         lsb_pkg::OP_BRIGHT: begin
            mode = lsb_pkg::MODE_BRIGHT;
            expected_duty.push_back(bright_level);
         end
         lsb_pkg::OP_PULSE: begin
            mode = lsb_pkg::MODE_PULSE;
            last_update = '0;
         end
         default: begin
            if (mode == lsb_pkg::MODE_PULSE) begin
               age = now - last_update;
               if (last_update != 0 && age < lsb_pkg::RATE_LIMIT_MS) begin
                  limited++;
               end else begin
                  last_update = now;
                  updates++;
                  expected_duty.push_back(breathe_duty(now));
               end
            end
         end
      endcase
   endfunction

   // Called for every accepted duty word.
   function void check_duty(bit [7:0] actual);
      bit [7:0] want;
      words_out++;
      if (expected_duty.size() == 0) begin
         $error("duty: no word expected, actual %0d", actual);
         errors++;
      end else begin
         want = expected_duty.pop_front();
         if (want != actual) begin
            $error("duty: expected %0d, actual %0d", want, actual);
            errors++;
         end
      end
   endfunction

endclass

module led_sine_breathing_pwm_tb;
   import lsb_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 110;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op       = OP_OFF;
   logic [31:0]            req_now_ms   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   logic [DUTY_W-1:0]      rsp_duty;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = CSR_BRIGHT_LEVEL;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   bit             quiet;
   bit             hold_rsp;
   int             idle_cycles;
   int             stall_cycles;
   duty_scoreboard duty_sb;

   led_sine_breathing_pwm i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_now_ms   (req_now_ms),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_duty     (rsp_duty),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog on progress, and a count of cycles the request side is stalled.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (req_valid && !req_ready) begin
         stall_cycles <= stall_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offers one request word after a random gap, none when quiet, and waits for its acceptance.
   task automatic send_request(op_type op, logic [31:0] now);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      duty_sb.note_request(op, now);
   endtask

   // Leaves the write enable high so that writes can follow back to back.
   task automatic write_csr(csr_index_type index, logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      duty_sb.write_reg(index, data);
   endtask

   task automatic apply_settings(logic [15:0] bright, logic [15:0] low,
                                 logic [15:0] high, logic [15:0] period);
      write_csr(CSR_BRIGHT_LEVEL, bright);
      write_csr(CSR_PULSE_LOW, low);
      write_csr(CSR_PULSE_HIGH, high);
      write_csr(CSR_PERIOD_MS, period);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every expected duty has arrived, then lets the datapath settle.
   task automatic settle();
      req_valid <= 1'b0;
      while (duty_sb.expected_duty.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly breathing runs (start pulse, then ticks with small time steps that
   // straddle the rate limit), mixed with words of random op and time.
   task automatic run_phase(int words);
      int          sent;
      int          run;
      logic [31:0] stamp;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0) begin
               stamp = 32'hFFFF_FFFF - $urandom_range(0, 300);
            end else begin
               stamp = $urandom;
            end
            send_request(OP_PULSE, stamp);
            sent++;
            run = $urandom_range(4, 16);
            repeat (run) begin
               if ($urandom_range(0, 15) == 0) begin
                  stamp = $urandom;
               end else begin
                  stamp = stamp + $urandom_range(0, 40);
               end
               send_request(OP_TICK, stamp);
               sent++;
            end
         end else begin
            send_request(op_type'($urandom_range(0, 3)), $urandom);
            sent++;
         end
      end
   endtask

   // Response side: random stalls per word, none when quiet, one long hold on request.
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else if (quiet) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 3);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         duty_sb.check_duty(rsp_duty);
      end
   end

   initial begin : stimulus
      duty_sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: steady modes, tick outside breathing, zero timestamp,
      // rate limit on both sides of 15 ms and across the time wrap.
      send_request(OP_OFF, 32'd0);
      send_request(OP_BRIGHT, 32'hFFFF_FFFF);
      send_request(OP_TICK, 32'd100);
      send_request(OP_PULSE, 32'hFFFF_FFFF);
      send_request(OP_TICK, 32'd0);
      send_request(OP_TICK, 32'd5);
      send_request(OP_TICK, 32'd12);
      send_request(OP_TICK, 32'd20);
      send_request(OP_TICK, 32'hFFFF_FFFF);
      send_request(OP_TICK, 32'd3);
      send_request(OP_TICK, 32'd13);
      send_request(OP_TICK, 32'd14);
      send_request(OP_OFF, 32'h5555_AAAA);
      send_request(OP_TICK, 32'hAAAA_5555);

      // Reversed levels, a zero period that acts as the minimum, and upper
      // write-data bits that the 8-bit registers drop.
      settle();
      apply_settings(16'hFF00, 16'hAAC8, 16'h5510, 16'd0);
      send_request(OP_BRIGHT, 32'd7);
      send_request(OP_PULSE, 32'd0);
      send_request(OP_TICK, 32'd199);
      send_request(OP_TICK, 32'd200);
      send_request(OP_TICK, 32'd399);
      send_request(OP_TICK, 32'd1000000);

      // Largest period with equal levels.
      settle();
      apply_settings(16'd128, 16'd255, 16'd255, 16'hFFFF);
      send_request(OP_PULSE, 32'd1);
      send_request(OP_TICK, 32'd65534);
      send_request(OP_TICK, 32'd65535);
      send_request(OP_TICK, 32'hFFFF_FFFF);

      // Random phases; the first starts with a long response hold so that the
      // block fills up and pushes back on requests.
      settle();
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 3000)));
      hold_rsp = 1'b1;
      run_phase(PHASE_WORDS);

      settle();
      apply_settings(16'd255, 16'd0, 16'd255, 16'd200);
      run_phase(PHASE_WORDS);

      settle();
      quiet = 1'b1;
      apply_settings(16'd0, 16'd255, 16'd0, 16'hFFFF);
      run_phase(PHASE_WORDS);
      quiet = 1'b0;

      settle();
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 4000)));
      run_phase(PHASE_WORDS);

      settle();
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_phase(PHASE_WORDS);

      settle();
      $display("Covered %0d request words and %0d duty words:",
               duty_sb.words_in, duty_sb.words_out);
      $display("%0d breathing updates, %0d ticks dropped by the rate limit, %0d %s",
               duty_sb.updates, duty_sb.limited, stall_cycles,
               "cycles of request back-pressure.");
      if (duty_sb.errors == 0 && duty_sb.expected_duty.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
